FILE: src/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg: shared definitions for the clipped line rasterizer
// Field widths, result cap, parameter defaults and the pixel write record.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int TILE_POS_BITS  = 11;
    localparam int TILE_DIM_BITS  = 6;
    localparam int COLOR_BITS     = 16;
    localparam int INDEX_BITS     = 10;
    localparam int RESULT_CAP     = 32;
    localparam int CNT_BITS       = $clog2(RESULT_CAP + 1);

    localparam int DEF_MAX_TILE_W = 32;
    localparam int DEF_MAX_TILE_H = 32;
    localparam int DEF_COORD_BITS = 12;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [COLOR_BITS-1:0] color;
        logic                  wr_en;
        logic                  last;
    } pixel_t;

endpackage

FILE: src/clr_walk_unit.sv
// ----------------------------------------------------------------------------
// clr_walk_unit: Bresenham step and tile clip
// Tests the current point against the tile, forms its buffer index and
// works out the next point and error term.
// ----------------------------------------------------------------------------
module clr_walk_unit #(
    parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS,
    parameter int MAX_TILE_W = clr_pkg::DEF_MAX_TILE_W,
    parameter int MAX_TILE_H = clr_pkg::DEF_MAX_TILE_H
) (
    input  logic signed [COORD_BITS-1:0]            x,
    input  logic signed [COORD_BITS-1:0]            y,
    input  logic signed [COORD_BITS+2:0]            d,
    input  logic signed [COORD_BITS+2:0]            inc_a,
    input  logic signed [COORD_BITS+2:0]            inc_b,
    input  logic                                    x_major,
    input  logic                                    minor_neg,
    input  logic [clr_pkg::TILE_POS_BITS-1:0]       tx,
    input  logic [clr_pkg::TILE_POS_BITS-1:0]       ty,
    input  logic [$clog2(MAX_TILE_W+1)-1:0]         tw,
    input  logic [$clog2(MAX_TILE_H+1)-1:0]         th,
    output logic signed [COORD_BITS-1:0]            x_next,
    output logic signed [COORD_BITS-1:0]            y_next,
    output logic signed [COORD_BITS+2:0]            d_next,
    output logic                                    hit,
    output logic [clr_pkg::INDEX_BITS-1:0]          index
);
    import clr_pkg::*;

    localparam int REL_BITS  = ((COORD_BITS > TILE_POS_BITS) ? COORD_BITS : TILE_POS_BITS) + 2;
    localparam int TW_BITS   = $clog2(MAX_TILE_W + 1);
    localparam int TH_BITS   = $clog2(MAX_TILE_H + 1);
    localparam int PROD_BITS = TW_BITS + TH_BITS + 1;

    logic signed [REL_BITS-1:0]   rel_x;
    logic signed [REL_BITS-1:0]   rel_y;
    logic [PROD_BITS-1:0]         idx_wide;
    logic                         step_minor;
    logic signed [COORD_BITS-1:0] x_inc;
    logic signed [COORD_BITS-1:0] x_dec;
    logic signed [COORD_BITS-1:0] y_inc;
    logic signed [COORD_BITS-1:0] y_dec;

    assign rel_x = REL_BITS'(x) - $signed(REL_BITS'(tx));
    assign rel_y = REL_BITS'(y) - $signed(REL_BITS'(ty));

    // negative points and zero sized tiles fall out of these compares
    assign hit = !rel_x[REL_BITS-1] && (rel_x < $signed(REL_BITS'(tw))) &&
                 !rel_y[REL_BITS-1] && (rel_y < $signed(REL_BITS'(th)));

    assign idx_wide = PROD_BITS'($unsigned(TH_BITS'(rel_y))) * PROD_BITS'(tw) +
                      PROD_BITS'($unsigned(TW_BITS'(rel_x)));
    assign index    = INDEX_BITS'(idx_wide);

    assign step_minor = (d > 0);
    assign x_inc = x + COORD_BITS'(1);
    assign x_dec = x - COORD_BITS'(1);
    assign y_inc = y + COORD_BITS'(1);
    assign y_dec = y - COORD_BITS'(1);

    always_comb
    begin
        if (x_major)
        begin
            x_next = x_inc;
            y_next = step_minor ? (minor_neg ? y_dec : y_inc) : y;
        end
        else
        begin
            y_next = y_inc;
            x_next = step_minor ? (minor_neg ? x_dec : x_inc) : x;
        end
        d_next = step_minor ? (d + inc_b) : (d + inc_a);
    end

endmodule

FILE: src/clr_out_stage.sv
// ----------------------------------------------------------------------------
// clr_out_stage: result register
// Holds one pixel write until the downstream side takes it.
// ----------------------------------------------------------------------------
module clr_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  clr_pkg::pixel_t               pix,
    output logic                          free,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [clr_pkg::INDEX_BITS-1:0] pixel_index,
    output logic [clr_pkg::COLOR_BITS-1:0] pixel_color,
    output logic                          write_enable,
    output logic                          last
);
    import clr_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    pixel_t data_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = push ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= pix;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_index  = data_reg.index;
    assign pixel_color  = data_reg.color;
    assign write_enable = data_reg.wr_en;
    assign last         = data_reg.last;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> free)
        else $error("result register overwritten while held");

endmodule

FILE: src/clipped_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_unit: tile-clipped Bresenham line walker
// Walks one segment per transaction and emits the pixel writes inside a tile.
// ----------------------------------------------------------------------------
// One segment is taken while in_stall is low; in_stall then stays high until
// the segment's final result has been handed to the result register. A
// segment of major-axis length L passes the set-up states DIFF, ABS, INIT and
// INCB, takes L Bresenham steps in the walk unit, sees that the walk is done
// and issues the closing result. The walk ends early once the 32nd write
// is found.
// Each write is held back one find so that the final one can carry last;
// out_stall pauses the walk only when a held write must move on. A segment
// with no pixel in the tile yields one result with write_enable low and
// last high.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_unit #(
    parameter int MAX_TILE_W = clr_pkg::DEF_MAX_TILE_W,
    parameter int MAX_TILE_H = clr_pkg::DEF_MAX_TILE_H,
    parameter int COORD_BITS = clr_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic [clr_pkg::TILE_POS_BITS-1:0]   tile_x,
    input  logic [clr_pkg::TILE_POS_BITS-1:0]   tile_y,
    input  logic [clr_pkg::TILE_DIM_BITS-1:0]   tile_w,
    input  logic [clr_pkg::TILE_DIM_BITS-1:0]   tile_h,
    input  logic [clr_pkg::COLOR_BITS-1:0]      line_color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [clr_pkg::INDEX_BITS-1:0]      pixel_index,
    output logic [clr_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                write_enable,
    output logic                                last
);
    import clr_pkg::*;

    localparam int TW_BITS = $clog2(MAX_TILE_W + 1);
    localparam int TH_BITS = $clog2(MAX_TILE_H + 1);
    localparam int DW      = COORD_BITS + 3;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_ABS   = 3'd2;
    localparam logic [2:0] ST_INIT  = 3'd3;
    localparam logic [2:0] ST_INCB  = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_FINAL = 3'd6;

    logic [2:0] state_reg, state_next;

    logic signed [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [TILE_POS_BITS-1:0]     tx_reg, tx_next, ty_reg, ty_next;
    logic [TW_BITS-1:0]           tw_reg, tw_next;
    logic [TH_BITS-1:0]           th_reg, th_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;

    logic signed [COORD_BITS:0]   ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic signed [COORD_BITS:0]   adx_reg, adx_next, ady_reg, ady_next;
    logic                         x_major_reg, x_major_next;
    logic                         minor_neg_reg, minor_neg_next;
    logic signed [DW-1:0]         d_reg, d_next;
    logic signed [DW-1:0]         inc_a_reg, inc_a_next, inc_b_reg, inc_b_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [COORD_BITS-1:0]        rem_reg, rem_next;

    pixel_t                       hold_reg, hold_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;

    logic signed [COORD_BITS:0]   maj;
    logic signed [COORD_BITS:0]   mn;
    logic                         xm;

    logic signed [COORD_BITS-1:0] wx_next, wy_next;
    logic signed [DW-1:0]         wd_next;
    logic                         hit;
    logic [INDEX_BITS-1:0]        hit_index;

    logic                         push;
    pixel_t                       push_pix;
    logic                         out_free;

    clr_walk_unit #(
        .COORD_BITS (COORD_BITS),
        .MAX_TILE_W (MAX_TILE_W),
        .MAX_TILE_H (MAX_TILE_H)
    ) u_walk (
        .x         (x_reg),
        .y         (y_reg),
        .d         (d_reg),
        .inc_a     (inc_a_reg),
        .inc_b     (inc_b_reg),
        .x_major   (x_major_reg),
        .minor_neg (minor_neg_reg),
        .tx        (tx_reg),
        .ty        (ty_reg),
        .tw        (tw_reg),
        .th        (th_reg),
        .x_next    (wx_next),
        .y_next    (wy_next),
        .d_next    (wd_next),
        .hit       (hit),
        .index     (hit_index)
    );

    clr_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pix          (push_pix),
        .free         (out_free),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pixel_index  (pixel_index),
        .pixel_color  (pixel_color),
        .write_enable (write_enable),
        .last         (last)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        tw_next         = tw_reg;
        th_next         = th_reg;
        color_next      = color_reg;
        ddx_next        = ddx_reg;
        ddy_next        = ddy_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        x_major_next    = x_major_reg;
        minor_neg_next  = minor_neg_reg;
        d_next          = d_reg;
        inc_a_next      = inc_a_reg;
        inc_b_next      = inc_b_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        rem_next        = rem_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        cnt_next        = cnt_reg;
        push            = 1'b0;
        push_pix        = hold_reg;

        xm  = (ady_reg < adx_reg);
        maj = xm ? adx_reg : ady_reg;
        mn  = xm ? ady_reg : adx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ax_next    = start_x;
                    ay_next    = start_y;
                    bx_next    = end_x;
                    by_next    = end_y;
                    tx_next    = tile_x;
                    ty_next    = tile_y;
                    tw_next    = (int'(tile_w) > MAX_TILE_W) ? TW_BITS'(MAX_TILE_W)
                                                              : TW_BITS'(tile_w);
                    th_next    = (int'(tile_h) > MAX_TILE_H) ? TH_BITS'(MAX_TILE_H)
                                                              : TH_BITS'(tile_h);
                    color_next = line_color;
                    hold_valid_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                ddx_next   = (COORD_BITS+1)'(bx_reg) - (COORD_BITS+1)'(ax_reg);
                ddy_next   = (COORD_BITS+1)'(by_reg) - (COORD_BITS+1)'(ay_reg);
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                adx_next   = ddx_reg[COORD_BITS] ? -ddx_reg : ddx_reg;
                ady_next   = ddy_reg[COORD_BITS] ? -ddy_reg : ddy_reg;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                x_major_next   = xm;
                minor_neg_next = ddx_reg[COORD_BITS] ^ ddy_reg[COORD_BITS];
                // walk starts from the endpoint that is lower on the major axis
                if (xm ? ddx_reg[COORD_BITS] : ddy_reg[COORD_BITS])
                begin
                    x_next = bx_reg;
                    y_next = by_reg;
                end
                else
                begin
                    x_next = ax_reg;
                    y_next = ay_reg;
                end
                rem_next   = COORD_BITS'(maj);
                inc_a_next = DW'(mn) <<< 1;
                d_next     = (DW'(mn) <<< 1) - DW'(maj);
                state_next = ST_INCB;
            end
            ST_INCB:
            begin
                // 2*(minor - major) = (2*minor - major) - major
                inc_b_next = d_reg - $signed(DW'(rem_reg));
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_FINAL;
                end
                else if (!(hit && hold_valid_reg && !out_free))
                begin
                    x_next   = wx_next;
                    y_next   = wy_next;
                    d_next   = wd_next;
                    rem_next = rem_reg - COORD_BITS'(1);
                    if (hit)
                    begin
                        push            = hold_valid_reg;
                        hold_next.index = hit_index;
                        hold_next.color = color_reg;
                        hold_next.wr_en = 1'b1;
                        hold_next.last  = 1'b0;
                        hold_valid_next = 1'b1;
                        cnt_next        = cnt_reg + CNT_BITS'(1);
                        if (cnt_reg == CNT_BITS'(RESULT_CAP - 1))
                        begin
                            state_next = ST_FINAL;
                        end
                    end
                end
            end
            ST_FINAL:
            begin
                if (hold_valid_reg)
                begin
                    push_pix.last = 1'b1;
                end
                else
                begin
                    push_pix = '0;
                    push_pix.last = 1'b1;
                end
                if (out_free)
                begin
                    push            = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        tw_reg        <= tw_next;
        th_reg        <= th_next;
        color_reg     <= color_next;
        ddx_reg       <= ddx_next;
        ddy_reg       <= ddy_next;
        adx_reg       <= adx_next;
        ady_reg       <= ady_next;
        x_major_reg   <= x_major_next;
        minor_neg_reg <= minor_neg_next;
        d_reg         <= d_next;
        inc_a_reg     <= inc_a_next;
        inc_b_reg     <= inc_b_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        rem_reg       <= rem_next;
        hold_reg      <= hold_next;
    end

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(RESULT_CAP))
        else $error("write count beyond cap");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held write left over after line");

    a_disabled_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> last)
        else $error("disabled result without last");

    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && out_free) |=> (state_reg == ST_IDLE && out_valid && last))
        else $error("final result not issued");

endmodule
